@@ sv/kalman_filter_step_assert.svh @@
// ----------------------------------------------------------------------------
// kalman_filter_step_assert.svh
// Assertion macros for the Kalman filter step block.
// ----------------------------------------------------------------------------
`ifndef KALMAN_FILTER_STEP_ASSERT_SVH
`define KALMAN_FILTER_STEP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KFS_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KFS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ sv/kfs_pkg.sv @@
// ----------------------------------------------------------------------------
// kfs_pkg
// Types, region codes and fixed-point helpers for the Kalman filter step.
// ----------------------------------------------------------------------------
package kfs_pkg;

  localparam int STATE_DIM_DEF = 4;
  localparam int MEAS_DIM_DEF  = 2;
  localparam int CTRL_DIM_DEF  = 2;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ADDR_W    = 11;            // region, row, column
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  typedef logic [3:0] region_t;
  typedef logic [3:0] opcode_t;
  typedef logic [1:0] comb_t;

  // store regions; the first nine match the write opcodes
  localparam region_t RG_A   = 4'd0;
  localparam region_t RG_B   = 4'd1;
  localparam region_t RG_H   = 4'd2;
  localparam region_t RG_Q   = 4'd3;
  localparam region_t RG_R   = 4'd4;
  localparam region_t RG_X   = 4'd5;
  localparam region_t RG_P   = 4'd6;
  localparam region_t RG_U   = 4'd7;
  localparam region_t RG_Z   = 4'd8;
  localparam region_t RG_XB  = 4'd9;
  localparam region_t RG_AP  = 4'd10;       // also holds I - KH later
  localparam region_t RG_PB  = 4'd11;
  localparam region_t RG_Y   = 4'd12;
  localparam region_t RG_PHT = 4'd13;
  localparam region_t RG_AUG = 4'd14;
  localparam region_t RG_K   = 4'd15;

  localparam opcode_t OP_A    = 4'd0;
  localparam opcode_t OP_B    = 4'd1;
  localparam opcode_t OP_H    = 4'd2;
  localparam opcode_t OP_Q    = 4'd3;
  localparam opcode_t OP_R    = 4'd4;
  localparam opcode_t OP_X    = 4'd5;
  localparam opcode_t OP_P    = 4'd6;
  localparam opcode_t OP_U    = 4'd7;
  localparam opcode_t OP_Z    = 4'd8;
  localparam opcode_t OP_STEP = 4'd9;

  // how a finished dot product is merged before write-back
  localparam comb_t CB_NONE  = 2'd0;   // c = s
  localparam comb_t CB_ADD   = 2'd1;   // c = s + o
  localparam comb_t CB_SUBF  = 2'd2;   // c = o - s
  localparam comb_t CB_IDSUB = 2'd3;   // c = I - s

  typedef struct packed {
    region_t    a_reg;
    region_t    b_reg;
    region_t    c_reg;
    region_t    o_reg;
    logic [2:0] r_last;
    logic [2:0] m_last;
    logic [2:0] k_last;
    logic       bt;
    logic [3:0] b_ofs;
    comb_t      comb;
  } phase_t;

  function automatic logic [ADDR_W-1:0] mem_addr(region_t rg, logic [2:0] row,
                                                 logic [3:0] col);
    return {rg, row, col};
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_addsub(logic signed [31:0] a,
                                                    logic signed [31:0] b,
                                                    logic sub);
    logic [32:0] s;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else return s[31:0];
  endfunction

endpackage

@@ sv/kalman_filter_step.sv @@
// ----------------------------------------------------------------------------
// kalman_filter_step
// Linear Kalman predict and update step in signed fixed point, one shared
// multiply, add and divide datapath under a microcoded sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 2048-word store to zero, one word a
// cycle, and takes no beat during the sweep. Then each input beat
// either writes one element of A, B, H, Q, R, x, P, u or z (out-of-range
// indices are dropped) or, with opcode 9, runs a full step and returns
// STATE_DIM beats of the new x, singular set on all of them if
// elimination met a zero pivot (x and P then unchanged). The step is paced
// by the single store read port and the shared multiplier: each product
// term of a matrix product reads its two operands, multiplies and
// accumulates in turn, and each result element then reads its merge
// operand and is written; Gauss-Jordan elimination adds one restoring
// divide per pivot-row element and a read, multiply and write-back per
// eliminated element. Each output beat waits out the sink's stalls. The
// block takes no input beat while a step or its output is in progress.
// ----------------------------------------------------------------------------
`include "kalman_filter_step_assert.svh"

module kalman_filter_step
  import kfs_pkg::*;
#(
  parameter int STATE_DIM = STATE_DIM_DEF,
  parameter int MEAS_DIM  = MEAS_DIM_DEF,
  parameter int CTRL_DIM  = CTRL_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // row_index[2:0], col_index[5:3], value[37:6]
  input  logic [3:0]           s_tuser,   // opcode[3:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // state_index[2:0], state_value[34:3]
  output logic                 m_tuser,   // singular
  output logic                 m_tlast
);

  // dimension end values as index widths
  localparam logic [2:0] N_LAST   = 3'(STATE_DIM - 1);
  localparam logic [2:0] M_LAST   = 3'(MEAS_DIM - 1);
  localparam logic [2:0] C_LAST   = 3'(CTRL_DIM - 1);
  localparam logic [3:0] M_W      = 4'(MEAS_DIM);
  localparam logic [3:0] AUG_LAST = 4'(2 * MEAS_DIM - 1);
  localparam logic [3:0] LAST_PH  = 4'd10;
  localparam logic [3:0] GJ_PH    = 4'd6;    // phase after which S is inverted

  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

  // divider: |a| << FRAC_BITS over |b|, one quotient bit a cycle
  localparam int NUMW  = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUMW + 1);

  // sequencer codes
  localparam logic [4:0] ST_CLEAR   = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_MM_RA   = 5'd2;
  localparam logic [4:0] ST_MM_RB   = 5'd3;
  localparam logic [4:0] ST_MM_MUL  = 5'd4;
  localparam logic [4:0] ST_MM_ACC  = 5'd5;
  localparam logic [4:0] ST_MM_COMB = 5'd6;
  localparam logic [4:0] ST_MM_WR   = 5'd7;
  localparam logic [4:0] ST_GI      = 5'd8;
  localparam logic [4:0] ST_GP_RD   = 5'd9;
  localparam logic [4:0] ST_GP_CHK  = 5'd10;
  localparam logic [4:0] ST_GD_RD   = 5'd11;
  localparam logic [4:0] ST_GD_LD   = 5'd12;
  localparam logic [4:0] ST_GD_RUN  = 5'd13;
  localparam logic [4:0] ST_GD_WR   = 5'd14;
  localparam logic [4:0] ST_GE_ROW  = 5'd15;
  localparam logic [4:0] ST_GE_FRD  = 5'd16;
  localparam logic [4:0] ST_GE_FLD  = 5'd17;
  localparam logic [4:0] ST_GE_RC   = 5'd18;
  localparam logic [4:0] ST_GE_RR   = 5'd19;
  localparam logic [4:0] ST_GE_MUL  = 5'd20;
  localparam logic [4:0] ST_GE_WR   = 5'd21;
  localparam logic [4:0] ST_EM_RD   = 5'd22;
  localparam logic [4:0] ST_EM_LD   = 5'd23;
  localparam logic [4:0] ST_EM_WAIT = 5'd24;

  // Step program: each phase is c = a * b (b transposed if bt), merged
  // with o as comb says. Vectors sit in column 0 of their region.
  function automatic phase_t phase_desc(logic [3:0] ph);
    phase_t d;
    d = '{a_reg: RG_A, b_reg: RG_X, c_reg: RG_XB, o_reg: RG_XB, r_last: N_LAST,
          m_last: N_LAST, k_last: 3'd0, bt: 1'b0, b_ofs: 4'd0, comb: CB_NONE};
    unique case (ph)
      4'd0: begin                 // xbar = A x
      end
      4'd1: begin                 // xbar = B u + xbar
        d.a_reg = RG_B; d.b_reg = RG_U; d.m_last = C_LAST; d.comb = CB_ADD;
      end
      4'd2: begin                 // AP = A P
        d.b_reg = RG_P; d.c_reg = RG_AP; d.k_last = N_LAST;
      end
      4'd3: begin                 // Pbar = AP A' + Q
        d.a_reg = RG_AP; d.b_reg = RG_A; d.c_reg = RG_PB; d.o_reg = RG_Q;
        d.k_last = N_LAST; d.bt = 1'b1; d.comb = CB_ADD;
      end
      4'd4: begin                 // y = z - H xbar
        d.a_reg = RG_H; d.b_reg = RG_XB; d.c_reg = RG_Y; d.o_reg = RG_Z;
        d.r_last = M_LAST; d.comb = CB_SUBF;
      end
      4'd5: begin                 // PHt = Pbar H'
        d.a_reg = RG_PB; d.b_reg = RG_H; d.c_reg = RG_PHT; d.k_last = M_LAST;
        d.bt = 1'b1;
      end
      4'd6: begin                 // S = H PHt + R, into the left half of [S|I]
        d.a_reg = RG_H; d.b_reg = RG_PHT; d.c_reg = RG_AUG; d.o_reg = RG_R;
        d.r_last = M_LAST; d.k_last = M_LAST; d.comb = CB_ADD;
      end
      4'd7: begin                 // K = PHt inv(S)
        d.a_reg = RG_PHT; d.b_reg = RG_AUG; d.c_reg = RG_K; d.m_last = M_LAST;
        d.k_last = M_LAST; d.b_ofs = M_W;
      end
      4'd8: begin                 // x = K y + xbar
        d.a_reg = RG_K; d.b_reg = RG_Y; d.c_reg = RG_X; d.m_last = M_LAST;
        d.comb = CB_ADD;
      end
      4'd9: begin                 // I - K H
        d.a_reg = RG_K; d.b_reg = RG_H; d.c_reg = RG_AP; d.m_last = M_LAST;
        d.k_last = N_LAST; d.comb = CB_IDSUB;
      end
      4'd10: begin                // P = (I - K H) Pbar
        d.a_reg = RG_AP; d.b_reg = RG_PB; d.c_reg = RG_P; d.k_last = N_LAST;
      end
      default: begin
      end
    endcase
    return d;
  endfunction

  // store
  logic [31:0]       mem [MEM_DEPTH];
  logic [ADDR_W-1:0] raddr, waddr, clr_addr;
  logic [31:0]       wdata;
  logic              wen;
  logic signed [31:0] rdata;

  // sequencer and datapath registers
  logic [4:0]  state;
  logic [3:0]  ph;
  logic [2:0]  ii, tt;
  logic [3:0]  jj;
  logic signed [31:0] acc, opa, opb, fac, piv;
  logic signed [63:0] prod;
  logic        sing;
  logic [NUMW-1:0]  dnum;
  logic [31:0]      drem, dden;
  logic             dneg;
  logic [CNT_W-1:0] dcnt;
  logic [M_TDATA_W-1:0] out_data;
  logic        out_sing, out_last, out_valid;

  phase_t pd;
  assign pd = phase_desc(ph);

  // input beat fields
  opcode_t     in_op;
  logic [2:0]  in_row, in_col;
  logic [31:0] in_val;
  assign in_op  = s_tuser;
  assign in_row = s_tdata[2:0];
  assign in_col = s_tdata[5:3];
  assign in_val = s_tdata[37:6];

  logic in_acc;
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // element write decode: bounds per target, vectors ignore the column
  logic [2:0] wr_rlast, wr_clast;
  logic       wr_vec, wr_op;
  always_comb begin
    wr_rlast = N_LAST;
    wr_clast = N_LAST;
    wr_vec   = 1'b0;
    wr_op    = 1'b1;
    unique case (in_op)
      OP_A, OP_Q, OP_P: begin
      end
      OP_B: wr_clast = C_LAST;
      OP_H: wr_rlast = M_LAST;
      OP_R: begin
        wr_rlast = M_LAST;
        wr_clast = M_LAST;
      end
      OP_X: wr_vec = 1'b1;
      OP_U: begin
        wr_rlast = C_LAST;
        wr_vec   = 1'b1;
      end
      OP_Z: begin
        wr_rlast = M_LAST;
        wr_vec   = 1'b1;
      end
      default: wr_op = 1'b0;
    endcase
  end

  logic in_wr;
  assign in_wr = in_acc && wr_op && (in_row <= wr_rlast) && (wr_vec || in_col <= wr_clast);

  // shared multiplier, product registered before scaling
  logic signed [31:0] mul_x, mul_y, mulres;
  logic signed [63:0] prod_sh;
  assign mul_x   = (state == ST_GE_MUL) ? fac : opa;
  assign mul_y   = (state == ST_GE_MUL) ? opa : rdata;
  assign prod_sh = prod >>> FRAC_BITS;
  assign mulres  = sat32(prod_sh);

  // shared saturating adder
  logic signed [31:0] add_x, add_y, add_res;
  logic               add_sub;
  always_comb begin
    add_x   = acc;
    add_y   = '0;
    add_sub = 1'b0;
    priority case (state)
      ST_MM_ACC: add_y = mulres;
      ST_MM_WR: begin
        unique case (pd.comb)
          CB_ADD: add_y = rdata;
          CB_SUBF: begin
            add_x   = rdata;
            add_y   = acc;
            add_sub = 1'b1;
          end
          CB_IDSUB: begin
            add_x   = ({1'b0, ii} == jj) ? FX_ONE : '0;
            add_y   = acc;
            add_sub = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_GE_WR: begin
        add_x   = opb;
        add_y   = mulres;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_res = sat_addsub(add_x, add_y, add_sub);
  end

  // divider step and result
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [31:0] a_mag, b_mag;
  logic signed [31:0] quot;
  assign rem_sh = {drem, dnum[NUMW-1]};
  assign rem_ge = (rem_sh >= {1'b0, dden});
  assign a_mag  = rdata[31] ? 32'(-rdata) : rdata;
  assign b_mag  = piv[31] ? 32'(-piv) : piv;
  always_comb begin
    if (!dneg) quot = (dnum > NUMW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : dnum[31:0];
    else       quot = (dnum > NUMW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -dnum[31:0];
  end

  // store read address
  always_comb begin
    raddr = mem_addr(RG_AUG, ii, jj);
    unique case (state)
      ST_MM_RA:   raddr = mem_addr(pd.a_reg, ii, {1'b0, tt});
      ST_MM_RB:   raddr = pd.bt ? mem_addr(pd.b_reg, jj[2:0], {1'b0, tt})
                                : mem_addr(pd.b_reg, tt, jj + pd.b_ofs);
      ST_MM_COMB: raddr = mem_addr(pd.o_reg, ii, jj);
      ST_GP_RD:   raddr = mem_addr(RG_AUG, tt, {1'b0, tt});
      ST_GD_RD:   raddr = mem_addr(RG_AUG, tt, jj);
      ST_GE_FRD:  raddr = mem_addr(RG_AUG, ii, {1'b0, tt});
      ST_GE_RC:   raddr = mem_addr(RG_AUG, tt, jj);
      ST_GE_RR:   raddr = mem_addr(RG_AUG, ii, jj);
      ST_EM_RD:   raddr = mem_addr(RG_X, ii, 4'd0);
      default:    raddr = mem_addr(RG_AUG, ii, jj);
    endcase
  end

  // store write port
  always_comb begin
    wen   = 1'b0;
    waddr = mem_addr(pd.c_reg, ii, jj);
    wdata = add_res;
    priority case (state)
      ST_CLEAR: begin
        wen   = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_IDLE: begin
        wen   = in_wr;
        waddr = mem_addr(in_op, in_row, wr_vec ? 4'd0 : {1'b0, in_col});
        wdata = in_val;
      end
      ST_MM_WR: wen = 1'b1;
      ST_GI: begin
        wen   = 1'b1;
        waddr = mem_addr(RG_AUG, ii, jj + M_W);
        wdata = ({1'b0, ii} == jj) ? FX_ONE : '0;
      end
      ST_GD_WR: begin
        wen   = 1'b1;
        waddr = mem_addr(RG_AUG, tt, jj);
        wdata = quot;
      end
      ST_GE_WR: begin
        wen   = 1'b1;
        waddr = mem_addr(RG_AUG, ii, jj);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_MM_RB:  opa <= rdata;
      ST_MM_MUL: prod <= mul_x * mul_y;
      ST_GP_CHK: piv <= rdata;
      ST_GD_LD: begin
        dneg <= rdata[31] ^ piv[31];
        dnum <= {a_mag, FRAC_BITS'(0)};
        drem <= '0;
        dden <= b_mag;
      end
      ST_GD_RUN: begin
        drem <= rem_ge ? 32'(rem_sh - {1'b0, dden}) : rem_sh[31:0];
        dnum <= {dnum[NUMW-2:0], rem_ge};
      end
      ST_GE_FLD: fac <= rdata;
      ST_GE_RR:  opa <= rdata;
      ST_GE_MUL: begin
        prod <= mul_x * mul_y;
        opb  <= rdata;
      end
      ST_EM_LD: begin
        out_data <= {(M_TDATA_W-35)'(0), rdata, ii};
        out_sing <= sing;
        out_last <= (ii == N_LAST);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      ph        <= '0;
      ii        <= '0;
      jj        <= '0;
      tt        <= '0;
      acc       <= '0;
      sing      <= 1'b0;
      dcnt      <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc && in_op == OP_STEP) begin
            sing  <= 1'b0;
            ph    <= '0;
            ii    <= '0;
            jj    <= '0;
            tt    <= '0;
            acc   <= '0;
            state <= ST_MM_RA;
          end
        end
        ST_MM_RA:  state <= ST_MM_RB;
        ST_MM_RB:  state <= ST_MM_MUL;
        ST_MM_MUL: state <= ST_MM_ACC;
        ST_MM_ACC: begin
          acc <= add_res;
          if (tt == pd.m_last) begin
            tt    <= '0;
            state <= ST_MM_COMB;
          end else begin
            tt    <= tt + 1'b1;
            state <= ST_MM_RA;
          end
        end
        ST_MM_COMB: state <= ST_MM_WR;
        ST_MM_WR: begin
          acc <= '0;
          if (jj == {1'b0, pd.k_last}) begin
            jj <= '0;
            if (ii == pd.r_last) begin
              ii <= '0;
              if (ph == GJ_PH) begin
                state <= ST_GI;
              end else if (ph == LAST_PH) begin
                state <= ST_EM_RD;
              end else begin
                ph    <= ph + 1'b1;
                state <= ST_MM_RA;
              end
            end else begin
              ii    <= ii + 1'b1;
              state <= ST_MM_RA;
            end
          end else begin
            jj    <= jj + 1'b1;
            state <= ST_MM_RA;
          end
        end
        // right half of [S | I]
        ST_GI: begin
          if (jj == {1'b0, M_LAST}) begin
            jj <= '0;
            if (ii == M_LAST) begin
              ii    <= '0;
              tt    <= '0;
              state <= ST_GP_RD;
            end else begin
              ii <= ii + 1'b1;
            end
          end else begin
            jj <= jj + 1'b1;
          end
        end
        ST_GP_RD: state <= ST_GP_CHK;
        ST_GP_CHK: begin
          jj <= '0;
          ii <= '0;
          if (rdata == 0) begin
            sing  <= 1'b1;
            state <= ST_EM_RD;
          end else begin
            state <= ST_GD_RD;
          end
        end
        // pivot row divided by the pivot
        ST_GD_RD: state <= ST_GD_LD;
        ST_GD_LD: begin
          dcnt  <= CNT_W'(NUMW);
          state <= ST_GD_RUN;
        end
        ST_GD_RUN: begin
          dcnt <= dcnt - 1'b1;
          if (dcnt == CNT_W'(1)) state <= ST_GD_WR;
        end
        ST_GD_WR: begin
          if (jj == AUG_LAST) begin
            jj    <= '0;
            ii    <= '0;
            state <= ST_GE_ROW;
          end else begin
            jj    <= jj + 1'b1;
            state <= ST_GD_RD;
          end
        end
        // clear the pivot column from every other row
        ST_GE_ROW: begin
          if (ii == tt) begin
            if (ii == M_LAST) begin
              ii <= '0;
              if (tt == M_LAST) begin
                tt    <= '0;
                ph    <= ph + 1'b1;
                state <= ST_MM_RA;
              end else begin
                tt    <= tt + 1'b1;
                state <= ST_GP_RD;
              end
            end else begin
              ii <= ii + 1'b1;
            end
          end else begin
            state <= ST_GE_FRD;
          end
        end
        ST_GE_FRD: state <= ST_GE_FLD;
        ST_GE_FLD: begin
          jj    <= '0;
          state <= ST_GE_RC;
        end
        ST_GE_RC:  state <= ST_GE_RR;
        ST_GE_RR:  state <= ST_GE_MUL;
        ST_GE_MUL: state <= ST_GE_WR;
        ST_GE_WR: begin
          if (jj == AUG_LAST) begin
            jj <= '0;
            if (ii == M_LAST) begin
              ii <= '0;
              if (tt == M_LAST) begin
                tt    <= '0;
                ph    <= ph + 1'b1;
                state <= ST_MM_RA;
              end else begin
                tt    <= tt + 1'b1;
                state <= ST_GP_RD;
              end
            end else begin
              ii    <= ii + 1'b1;
              state <= ST_GE_ROW;
            end
          end else begin
            jj    <= jj + 1'b1;
            state <= ST_GE_RC;
          end
        end
        // output beats, one per state element
        ST_EM_RD: state <= ST_EM_LD;
        ST_EM_LD: begin
          out_valid <= 1'b1;
          state     <= ST_EM_WAIT;
        end
        ST_EM_WAIT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (ii == N_LAST) begin
              ii    <= '0;
              state <= ST_IDLE;
            end else begin
              ii    <= ii + 1'b1;
              state <= ST_EM_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_sing;
  assign m_tlast  = out_last;

  // checks
  `KFS_ASSERT_NOW(a_no_take_while_out, m_tvalid, !s_tready, "input taken during output")
  `KFS_ASSERT_NEXT(a_step_starts, s_tvalid && s_tready && s_tuser == OP_STEP,
                   state == ST_MM_RA && !sing, "step did not start")
  `KFS_ASSERT_NEXT(a_last_ends, m_tvalid && m_tready && m_tlast, state == ST_IDLE,
                   "block not idle after last beat")
  `KFS_ASSERT_NOW(a_sing_stable, m_tvalid && $past(m_tvalid), m_tuser == $past(m_tuser),
                  "singular flag changed within one step")

endmodule
